/* rtl/core/jsu_pkg.sv */
`default_nettype none

package jsu_pkg;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_CHAR    = 3'd0,
    ST_CLOSED  = 3'd1,
    ST_NOQUOTE = 3'd2,
    ST_BADHEX  = 3'd3,
    ST_FAIL    = 3'd4
  } status_t;

  localparam logic [15:0] CH_QUOTE  = 16'h0022;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_SLASH  = 16'h002F;
  localparam logic [15:0] CH_B      = 16'h0062;
  localparam logic [15:0] CH_F      = 16'h0066;
  localparam logic [15:0] CH_N      = 16'h006E;
  localparam logic [15:0] CH_R      = 16'h0072;
  localparam logic [15:0] CH_T      = 16'h0074;
  localparam logic [15:0] CH_U      = 16'h0075;

  localparam logic [15:0] CODE_BS   = 16'h0008;
  localparam logic [15:0] CODE_FF   = 16'h000C;
  localparam logic [15:0] CODE_LF   = 16'h000A;
  localparam logic [15:0] CODE_CR   = 16'h000D;
  localparam logic [15:0] CODE_TAB  = 16'h0009;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] hex_accum;
    logic [1:0]  hex_digits;
  } dec_state_t;

  typedef struct packed {
    dec_state_t  next;
    logic        emit;
    logic [15:0] char_out;
    status_t     status;
  } step_t;

endpackage

`default_nettype wire

/* rtl/core/jsu_step.sv */
`default_nettype none

module jsu_step (
  input  wire jsu_pkg::dec_state_t cur,
  input  wire logic [15:0]         char_in,
  input  wire logic                at_end,
  output jsu_pkg::step_t           step
);

  logic       hex_ok;
  logic [3:0] hex_val;
  logic [15:0] hex_shift;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (char_in >= 16'h0030 && char_in <= 16'h0039) begin
      hex_val = 4'(char_in - 16'h0030);
    end else if (char_in >= 16'h0061 && char_in <= 16'h0066) begin
      hex_val = 4'(char_in - 16'h0057);
    end else if (char_in >= 16'h0041 && char_in <= 16'h0046) begin
      hex_val = 4'(char_in - 16'h0037);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_shift = {cur.hex_accum[11:0], hex_val};

  always_comb begin
    step.next     = cur;
    step.emit     = 1'b0;
    step.char_out = 16'd0;
    step.status   = jsu_pkg::ST_CHAR;
    unique case (cur.phase)
      jsu_pkg::PH_BODY: begin
        if (at_end) begin
          step.next.phase = jsu_pkg::PH_WAIT;
          step.emit       = 1'b1;
          step.status     = jsu_pkg::ST_NOQUOTE;
        end else if (char_in == jsu_pkg::CH_QUOTE) begin
          step.next.phase = jsu_pkg::PH_WAIT;
          step.emit       = 1'b1;
          step.status     = jsu_pkg::ST_CLOSED;
        end else if (char_in == jsu_pkg::CH_BSLASH) begin
          step.next.phase = jsu_pkg::PH_ESC;
        end else begin
          step.emit     = 1'b1;
          step.char_out = char_in;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (at_end) begin
          step.next.phase = jsu_pkg::PH_WAIT;
          step.emit       = 1'b1;
          step.status     = jsu_pkg::ST_NOQUOTE;
        end else begin
          step.next.phase = jsu_pkg::PH_BODY;
          step.emit       = 1'b1;
          unique case (char_in)
            jsu_pkg::CH_QUOTE:  step.char_out = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BSLASH: step.char_out = jsu_pkg::CH_BSLASH;
            jsu_pkg::CH_SLASH:  step.char_out = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_B:      step.char_out = jsu_pkg::CODE_BS;
            jsu_pkg::CH_F:      step.char_out = jsu_pkg::CODE_FF;
            jsu_pkg::CH_N:      step.char_out = jsu_pkg::CODE_LF;
            jsu_pkg::CH_R:      step.char_out = jsu_pkg::CODE_CR;
            jsu_pkg::CH_T:      step.char_out = jsu_pkg::CODE_TAB;
            jsu_pkg::CH_U: begin
              step.emit            = 1'b0;
              step.next.phase      = jsu_pkg::PH_HEX;
              step.next.hex_accum  = 16'd0;
              step.next.hex_digits = 2'd0;
            end
            default: step.emit = 1'b0;
          endcase
        end
      end
      jsu_pkg::PH_HEX: begin
        if (at_end || !hex_ok) begin
          step.next.phase = jsu_pkg::PH_WAIT;
          step.emit       = 1'b1;
          step.status     = jsu_pkg::ST_BADHEX;
        end else begin
          step.next.hex_accum = hex_shift;
          if (cur.hex_digits == 2'd3) begin
            step.next.hex_digits = 2'd0;
            step.next.phase      = jsu_pkg::PH_BODY;
            step.emit            = 1'b1;
            step.char_out        = hex_shift;
          end else begin
            step.next.hex_digits = cur.hex_digits + 2'd1;
          end
        end
      end
      default: begin
        if (at_end) begin
          step.next.phase = jsu_pkg::PH_WAIT;
          step.emit       = 1'b1;
          step.status     = jsu_pkg::ST_FAIL;
        end else begin
          step.next.phase = jsu_pkg::PH_BODY;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/json_string_unescaper_top.sv */
// JSON string unescaper.
// Input stream: one transaction per UTF-16 code unit on s_axis_tdata, or an
// end-of-input mark on s_axis_tuser (data then ignored). The first unit of
// each string is taken as its opening quote, whatever its value; the rest pass
// through with backslash escapes and \uXXXX sequences decoded.
// Output stream: zero or one transaction per input transaction, carrying the
// decoded unit on m_axis_tdata and a status code on m_axis_tuser
// (0 char, 1 string closed, 2 no closing quote, 3 bad hex, 4 stream failure).
// Each input transaction passes through an input register and a result
// register, with one step of decode between them.
// Throughput: up to one transaction per cycle in both directions while
// m_axis_tready stays high; phase and hex accumulator decode combinationally.
// Reset: both register stages empty, decoder waiting for an opening quote.
// Stall: while m_axis_tready is low and a result is held, the input register
// holds its item and s_axis_tready drops once that register is full.
`default_nettype none

module json_string_unescaper_top #(
  parameter int CHAR_BITS = 16
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [15:0] s_axis_tdata,   // [15:0] char_in
  input  wire  logic        s_axis_tuser,   // [0] at_end
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [15:0] char_out
  output logic [2:0]        m_axis_tuser    // [2:0] status
);

  localparam int          MaskBits = (CHAR_BITS < 16) ? CHAR_BITS : 16;
  localparam logic [15:0] CharMask = 16'((17'h1 << MaskBits) - 17'h1);

  logic                in_valid;
  logic [15:0]         in_char;
  logic                in_end;
  jsu_pkg::dec_state_t state;
  jsu_pkg::step_t      step;
  logic                adv;
  logic [15:0]         out_char;
  jsu_pkg::status_t    out_status;

  assign adv           = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  jsu_step u_step (
    .cur     (state),
    .char_in (in_char),
    .at_end  (in_end),
    .step    (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_end  <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= jsu_pkg::PH_WAIT;
      state.hex_accum  <= 16'd0;
      state.hex_digits <= 2'd0;
    end else if (adv) begin
      state <= step.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= step.emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && step.emit) begin
      out_char   <= step.char_out & CharMask;
      out_status <= step.status;
    end
  end

  assign m_axis_tdata = out_char;
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

/* test/unescape_checker.sv */
`default_nettype none

module unescape_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] char_in
  input  wire logic        s_axis_tuser,   // [0] at_end
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,   // [15:0] char_out
  input  wire logic [2:0]  m_axis_tuser,   // [2:0] status
  output int               errors,
  output int               pending,
  output int               results
);

  localparam logic [15:0] DIG_0 = 16'h0030;
  localparam logic [15:0] DIG_9 = 16'h0039;
  localparam logic [15:0] LC_A  = 16'h0061;
  localparam logic [15:0] LC_F  = 16'h0066;
  localparam logic [15:0] UC_A  = 16'h0041;
  localparam logic [15:0] UC_F  = 16'h0046;

  typedef struct packed {
    logic [15:0]      char_out;
    jsu_pkg::status_t status;
  } decoded_t;

  decoded_t         decoded_q[$];
  jsu_pkg::phase_t  phase = jsu_pkg::PH_WAIT;
  logic [15:0]      accum = '0;
  logic [1:0]       digits = '0;

  function automatic int hex_nibble(input logic [15:0] c);
    if (c >= DIG_0 && c <= DIG_9) return int'(c - DIG_0);
    if (c >= LC_A && c <= LC_F) return int'(c - LC_A) + 10;
    if (c >= UC_A && c <= UC_F) return int'(c - UC_A) + 10;
    return -1;
  endfunction

  // Advance the decoder by one input transaction; return 1 when it yields a result.
  function automatic bit decode_unit(input logic [15:0] c, input logic eoi,
                                     output decoded_t d);
    int v;
    d.char_out = '0;
    d.status   = jsu_pkg::ST_CHAR;
    case (phase)
      jsu_pkg::PH_BODY: begin
        if (eoi) begin
          phase = jsu_pkg::PH_WAIT;
          d.status = jsu_pkg::ST_NOQUOTE;
          return 1;
        end
        if (c == jsu_pkg::CH_QUOTE) begin
          phase = jsu_pkg::PH_WAIT;
          d.status = jsu_pkg::ST_CLOSED;
          return 1;
        end
        if (c == jsu_pkg::CH_BSLASH) begin
          phase = jsu_pkg::PH_ESC;
          return 0;
        end
        d.char_out = c;
        return 1;
      end
      jsu_pkg::PH_ESC: begin
        if (eoi) begin
          phase = jsu_pkg::PH_WAIT;
          d.status = jsu_pkg::ST_NOQUOTE;
          return 1;
        end
        phase = jsu_pkg::PH_BODY;
        case (c) inside
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: d.char_out = c;
          jsu_pkg::CH_B: d.char_out = jsu_pkg::CODE_BS;
          jsu_pkg::CH_F: d.char_out = jsu_pkg::CODE_FF;
          jsu_pkg::CH_N: d.char_out = jsu_pkg::CODE_LF;
          jsu_pkg::CH_R: d.char_out = jsu_pkg::CODE_CR;
          jsu_pkg::CH_T: d.char_out = jsu_pkg::CODE_TAB;
          jsu_pkg::CH_U: begin
            phase  = jsu_pkg::PH_HEX;
            accum  = '0;
            digits = '0;
            return 0;
          end
          default: return 0;
        endcase
        return 1;
      end
      jsu_pkg::PH_HEX: begin
        v = hex_nibble(c);
        if (eoi || v < 0) begin
          phase = jsu_pkg::PH_WAIT;
          d.status = jsu_pkg::ST_BADHEX;
          return 1;
        end
        accum = {accum[11:0], v[3:0]};
        if (digits == 2'd3) begin
          digits = '0;
          phase = jsu_pkg::PH_BODY;
          d.char_out = accum;
          return 1;
        end
        digits = digits + 2'd1;
        return 0;
      end
      default: begin
        if (eoi) begin
          phase = jsu_pkg::PH_WAIT;
          d.status = jsu_pkg::ST_FAIL;
          return 1;
        end
        phase = jsu_pkg::PH_BODY;
        return 0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    decoded_t d;
    decoded_t want;
    if (rst) begin
      phase  = jsu_pkg::PH_WAIT;
      accum  = '0;
      digits = '0;
      decoded_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (decode_unit(s_axis_tdata, s_axis_tuser, d)) decoded_q.push_back(d);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results++;
        if (decoded_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected output transaction: char 0x%04h status %0d",
                     m_axis_tdata, m_axis_tuser);
        end else begin
          want = decoded_q.pop_front();
          if (want.char_out !== m_axis_tdata || want.status !== m_axis_tuser) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch on output %0d: char exp 0x%04h got 0x%04h,",
                        " status exp %0d got %0d"},
                       results, want.char_out, m_axis_tdata, want.status, m_axis_tuser);
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;

  typedef struct {
    logic [15:0] c;
    logic        eoi;
  } tok_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  int   errors;
  int   pending;
  int   results;
  int   src_idle = 0;
  int   sink_idle = 0;
  int   hold_req = 0;
  int   hold_done = 0;
  int   quiet = 0;
  int   units_sent = 0;
  int   strings_built = 0;
  tok_t script[$];

  always #2 clk = ~clk;

  json_string_unescaper_top uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  unescape_checker chk (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .errors       (errors),
    .pending      (pending),
    .results      (results)
  );

  // Receiver: random backpressure, or a long hold when requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done++;
      end
      m_axis_tready = ($urandom_range(0, 99) >= sink_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic void push_char(input logic [15:0] c);
    tok_t t;
    t.c = c;
    t.eoi = 1'b0;
    script.push_back(t);
  endfunction

  function automatic void push_eoi();
    tok_t t;
    t.c = 16'($urandom_range(0, 65535));
    t.eoi = 1'b1;
    script.push_back(t);
  endfunction

  function automatic logic [15:0] hex_char();
    int n;
    n = $urandom_range(0, 21);
    if (n < 10) return 16'h0030 + 16'(n);
    if (n < 16) return 16'h0061 + 16'(n - 10);
    return 16'h0041 + 16'(n - 16);
  endfunction

  function automatic logic [15:0] escape_char();
    case ($urandom_range(0, 7))
      0: return jsu_pkg::CH_QUOTE;
      1: return jsu_pkg::CH_BSLASH;
      2: return jsu_pkg::CH_SLASH;
      3: return jsu_pkg::CH_B;
      4: return jsu_pkg::CH_F;
      5: return jsu_pkg::CH_N;
      6: return jsu_pkg::CH_R;
      default: return jsu_pkg::CH_T;
    endcase
  endfunction

  function automatic logic [15:0] non_hex_char();
    case ($urandom_range(0, 9))
      0: return 16'h0020;
      1: return 16'h002B;
      2: return 16'h002D;
      3: return 16'h0078;
      4: return 16'h0067;
      5: return 16'h0047;
      6: return 16'h003A;
      7: return 16'h0040;
      8: return 16'hFF10;
      default: return 16'h0130;
    endcase
  endfunction

  function automatic logic [15:0] plain_char();
    logic [15:0] c;
    do begin
      if ($urandom_range(0, 1)) c = 16'($urandom_range(16'h0020, 16'h007E));
      else c = 16'($urandom_range(0, 65535));
    end while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH);
    return c;
  endfunction

  // Queue a string: [end mark,] opening unit, random body, closing quote or broken end.
  function automatic void build_string();
    int len;
    int r;
    int k;
    strings_built++;
    if ($urandom_range(0, 99) < 5) push_eoi();
    if ($urandom_range(0, 9) == 0) push_char(16'($urandom_range(0, 65535)));
    else push_char(jsu_pkg::CH_QUOTE);
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        push_char(plain_char());
      end else if (r < 70) begin
        push_char(jsu_pkg::CH_BSLASH);
        push_char(escape_char());
      end else if (r < 85) begin
        push_char(jsu_pkg::CH_BSLASH);
        push_char(jsu_pkg::CH_U);
        repeat (4) push_char(hex_char());
      end else if (r < 93) begin
        push_char(jsu_pkg::CH_BSLASH);
        push_char(16'($urandom_range(0, 65535)));
      end else begin
        push_char(jsu_pkg::CH_BSLASH);
        push_char(jsu_pkg::CH_U);
        k = $urandom_range(0, 3);
        repeat (k) push_char(hex_char());
        if ($urandom_range(0, 2) == 0) push_eoi();
        else push_char(non_hex_char());
        return;
      end
    end
    r = $urandom_range(0, 99);
    if (r < 85) begin
      push_char(jsu_pkg::CH_QUOTE);
    end else if (r < 95) begin
      push_eoi();
    end else begin
      push_char(jsu_pkg::CH_BSLASH);
      push_eoi();
    end
  endfunction

  task automatic send_script();
    tok_t t;
    while (script.size() > 0) begin
      t = script.pop_front();
      @(negedge clk);
      while ($urandom_range(0, 99) < src_idle) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk);
      end
      s_axis_tvalid = 1'b1;
      s_axis_tdata  = t.c;
      s_axis_tuser  = t.eoi;
      do @(posedge clk); while (!s_axis_tready);
      units_sent++;
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = units_sent + count;
    while (units_sent < target) begin
      build_string();
      send_script();
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle  = 37;
    sink_idle = 56;

    push_eoi();
    push_char(16'h0041);
    push_char(16'hFFFF);
    push_char(16'h0000);
    push_char(jsu_pkg::CH_BSLASH);
    push_char(jsu_pkg::CH_QUOTE);
    push_char(jsu_pkg::CH_BSLASH);
    push_char(jsu_pkg::CH_U);
    push_char(16'h0046);
    push_char(16'h0066);
    push_char(16'h0030);
    push_char(16'h0039);
    push_char(jsu_pkg::CH_BSLASH);
    push_char(16'h0071);
    push_char(jsu_pkg::CH_QUOTE);
    push_char(jsu_pkg::CH_QUOTE);
    push_char(jsu_pkg::CH_BSLASH);
    push_char(jsu_pkg::CH_U);
    push_char(16'h0067);
    push_char(jsu_pkg::CH_QUOTE);
    push_char(jsu_pkg::CH_BSLASH);
    push_char(jsu_pkg::CH_U);
    push_char(16'h0041);
    push_eoi();
    push_char(jsu_pkg::CH_QUOTE);
    push_char(jsu_pkg::CH_BSLASH);
    push_eoi();
    push_char(jsu_pkg::CH_QUOTE);
    push_eoi();
    strings_built += 5;
    send_script();

    run_random(150);
    hold_req++;
    run_random(320);
    drain();

    src_idle  = 56;
    sink_idle = 37;
    run_random(460);
    drain();

    src_idle  = 0;
    sink_idle = 0;
    run_random(450);
    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d strings in %0d input transactions; %0d output transactions checked,",
             strings_built, units_sent, results);
    $display("with escapes, hex runs, error endings, backpressure and a long output hold.");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/core/jsu_pkg.sv
rtl/core/jsu_step.sv
rtl/core/json_string_unescaper_top.sv
test/unescape_checker.sv
test/testbench.sv
